### src/gfme_pkg.sv
// package for the gate fusion matrix engine
// holds operation codes, sequencer states and the value width; no dependencies
package gfme_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_APPLY = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_COPY,
    ST_COPY_LAST,
    ST_ROW,
    ST_MAC,
    ST_MAC_WAIT,
    ST_WRITE,
    ST_READ_WAIT,
    ST_READ_OUT
  } state_t;

  localparam int VAL_W = 16;

endpackage

### src/gate_fusion_matrix_engine_top.sv
// gate fusion matrix engine: fused complex kernel with clear, load, apply and read
// load writes the gate memory while idle; read registers the entry, then raises the strobe;
// clear writes the identity over every kernel entry; apply: copy pass into scratch, then
// per kernel entry 2^g products through one complex mac, written back to the kernel
// busy stays high during multi-cycle work; the strobe cannot be stalled by the receiver
// reset runs the identity clear pass before start is taken
module gate_fusion_matrix_engine_top
  import gfme_pkg::*;
#(
  parameter int MAX_FUSED_QUBITS = 5,
  parameter int MAX_GATE_QUBITS  = 3,
  parameter int FRAC_BITS        = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_wdata,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic [9:0]         entry_index,
  input  logic signed [15:0] value_re,
  input  logic signed [15:0] value_im,
  input  logic [1:0]         gate_qubits,
  input  logic [4:0]         qubit_mask,
  input  logic [5:0]         gate_perm,
  output logic               result_valid,
  output logic signed [15:0] entry_re,
  output logic signed [15:0] entry_im
);
  localparam int F     = MAX_FUSED_QUBITS;
  localparam int KA    = 2 * F;
  localparam int KD    = 1 << KA;
  localparam int GQ    = MAX_GATE_QUBITS;
  localparam int GA    = 2 * GQ;
  localparam int GD    = 1 << GA;
  localparam int FW    = $clog2(F + 1) < 3 ? 3 : $clog2(F + 1);
  localparam int ONE_I = (FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS);
  localparam logic [15:0] ONE = 16'(ONE_I);

  state_t state, state_next;

  logic [2:0]    fused_qubits;
  logic [FW-1:0] f_eff;
  logic [1:0]    g_r;
  logic [4:0]    mask_r;
  logic [5:0]    perm_r;
  logic [F-1:0]  row, col;
  logic [GQ:0]   kcnt;
  logic [KA:0]   sweep;
  logic          rd_zero;
  logic          mac_issue, mac_issue_d;

  logic          k_we, s_we, g_we;
  logic [KA-1:0] k_waddr, k_raddr, s_raddr;
  logic [31:0]   k_wdata, k_rdata, s_rdata, g_rdata;
  logic [GA-1:0] g_raddr;

  logic signed [15:0] mac_re, mac_im;

  // clamp the fused count
  always_comb begin
    f_eff = FW'(fused_qubits);
    if (fused_qubits == 3'd0) f_eff = FW'(1);
    if (FW'(fused_qubits) > FW'(F)) f_eff = FW'(F);
  end

  logic [F-1:0] side_m1;
  assign side_m1 = F'((1 << f_eff) - 1);

  // apply validity check
  logic [2:0] popc;
  logic       apply_ok;
  always_comb begin
    popc = '0;
    for (int q = 0; q < 5; q++) popc = popc + 3'(qubit_mask[q]);
    apply_ok = (gate_qubits != 2'd0) && (int'(gate_qubits) <= GQ) &&
               ((qubit_mask >> f_eff) == 5'd0) && (popc == {1'b0, gate_qubits});
  end

  // gate and kernel index formation for the current product
  logic [2:0]    gr, gk;
  logic [3:0]    pr, pk;
  logic [F-1:0]  krow;
  always_comb begin
    int pos;
    logic [F-1:0] tmp;
    gr = '0; tmp = '0; pos = 0;
    for (int q = 0; q < F; q++) begin
      if (q < 5 && mask_r[q]) begin
        gr[pos[1:0]] = row[q];
        tmp[q] = kcnt[pos[1:0]];
        pos = pos + 1;
      end
    end
    gk = 3'(kcnt[GQ-1:0]);
    krow = (row & ~F'(mask_r)) | tmp;
    pr = '0; pk = '0;
    for (int q = 0; q < 3; q++) begin
      if (q < int'(g_r)) begin
        pr[perm_r[2*q +: 2]] = pr[perm_r[2*q +: 2]] | gr[q];
        pk[perm_r[2*q +: 2]] = pk[perm_r[2*q +: 2]] | gk[q];
      end
    end
    // bits moved at or above the gate size are dropped
    pr = pr & 4'((1 << g_r) - 1);
    pk = pk & 4'((1 << g_r) - 1);
  end

  assign g_raddr = GA'((6'(pr[2:0]) << g_r) | 6'(pk[2:0]));
  assign s_raddr = {krow, col};

  gfme_ram #(.WIDTH(32), .DEPTH(KD)) u_kernel (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .raddr(k_raddr), .rdata(k_rdata)
  );
  gfme_ram #(.WIDTH(32), .DEPTH(KD)) u_scratch (
    .clk(clk), .we(s_we), .waddr(KA'(sweep - 1'b1)), .wdata(k_rdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );
  gfme_ram #(.WIDTH(32), .DEPTH(GD)) u_gate (
    .clk(clk), .we(g_we), .waddr(entry_index[GA-1:0]),
    .wdata({value_im, value_re}), .raddr(g_raddr), .rdata(g_rdata)
  );

  gfme_cmac #(.FRAC_BITS(FRAC_BITS), .ACC_W(48)) u_mac (
    .clk(clk), .clr(state == ST_ROW), .en(mac_issue_d),
    .ar(g_rdata[15:0]), .ai(g_rdata[31:16]),
    .br(s_rdata[15:0]), .bi(s_rdata[31:16]),
    .res_re(mac_re), .res_im(mac_im)
  );

  logic take;
  assign take = start && !busy;
  assign busy = (state != ST_IDLE);

  logic last_k;
  assign last_k = (kcnt == (GQ + 1)'((1 << g_r) - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          unique case (op_t'(operation))
            OP_CLEAR: state_next = ST_CLEAR;
            OP_LOAD:  state_next = ST_IDLE;
            OP_APPLY: state_next = apply_ok ? ST_COPY : ST_IDLE;
            OP_READ:  state_next = ST_READ_WAIT;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR:     if (sweep == (KA + 1)'(KD - 1)) state_next = ST_IDLE;
      ST_COPY:      if (sweep == (KA + 1)'(KD - 1)) state_next = ST_COPY_LAST;
      ST_COPY_LAST: state_next = ST_ROW;
      ST_ROW:       state_next = ST_MAC;
      ST_MAC:       if (last_k) state_next = ST_MAC_WAIT;
      ST_MAC_WAIT:  if (!mac_issue_d && !mac_issue) state_next = ST_WRITE;
      ST_WRITE: begin
        if (col == side_m1 && row == side_m1) state_next = ST_IDLE;
        else state_next = ST_ROW;
      end
      ST_READ_WAIT: state_next = ST_READ_OUT;
      ST_READ_OUT:  state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    k_we = 1'b0; k_waddr = '0; k_wdata = '0; k_raddr = KA'(sweep);
    s_we = 1'b0; g_we = 1'b0;
    unique case (state)
      ST_IDLE: begin
        g_we = take && (op_t'(operation) == OP_LOAD) && (entry_index < 10'(GD));
        k_raddr = KA'({entry_index >> f_eff, F'(0)} | KA'(entry_index & 10'(side_m1)));
      end
      ST_CLEAR: begin
        k_we = 1'b1; k_waddr = KA'(sweep);
        k_wdata = (sweep[KA-1:F] == sweep[F-1:0]) ? {16'h0, ONE} : 32'h0;
      end
      ST_COPY:      s_we = (sweep != '0);
      ST_COPY_LAST: s_we = 1'b1;
      ST_WRITE: begin
        k_we = 1'b1; k_waddr = {row, col}; k_wdata = {mac_im, mac_re};
      end
      default: ;
    endcase
  end

  assign mac_issue = (state == ST_MAC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      sweep        <= '0;
      fused_qubits <= 3'd1;
      result_valid <= 1'b0;
      mac_issue_d  <= 1'b0;
    end else begin
      state        <= state_next;
      mac_issue_d  <= mac_issue;
      result_valid <= (state == ST_READ_OUT);
      if (cfg_we) fused_qubits <= cfg_wdata;
      if (state == ST_CLEAR || state == ST_COPY) sweep <= sweep + 1'b1;
      else sweep <= '0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && take) begin
      g_r <= gate_qubits; mask_r <= qubit_mask; perm_r <= gate_perm;
      row <= '0; col <= '0;
      rd_zero <= (entry_index >> (2 * f_eff)) != 10'd0;
    end
    if (state == ST_ROW) kcnt <= '0;
    if (state == ST_MAC && !last_k) kcnt <= kcnt + 1'b1;
    if (state == ST_WRITE) begin
      col <= (col == side_m1) ? '0 : col + 1'b1;
      if (col == side_m1) row <= row + 1'b1;
    end
    // read data is only valid in the cycle after the address was taken
    if (state == ST_READ_WAIT) begin
      entry_re <= rd_zero ? 16'sd0 : k_rdata[15:0];
      entry_im <= rd_zero ? 16'sd0 : k_rdata[31:16];
    end
  end
endmodule

### src/gfme_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module gfme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/gfme_cmac.sv
// complex multiply-accumulate unit shared across the whole apply walk
// one complex product per cycle, registered products, wide accumulators; uses gfme_pkg
module gfme_cmac
  import gfme_pkg::*;
#(
  parameter int FRAC_BITS = 14,
  parameter int ACC_W = 40
) (
  input  logic                    clk,
  input  logic                    clr,
  input  logic                    en,
  input  logic signed [VAL_W-1:0] ar,
  input  logic signed [VAL_W-1:0] ai,
  input  logic signed [VAL_W-1:0] br,
  input  logic signed [VAL_W-1:0] bi,
  output logic signed [VAL_W-1:0] res_re,
  output logic signed [VAL_W-1:0] res_im
);
  logic signed [2*VAL_W-1:0] p_rr, p_ii, p_ri, p_ir;
  logic                      pv;
  logic signed [ACC_W-1:0]   acc_re, acc_im;

  always_ff @(posedge clk) begin
    p_rr <= ar * br;
    p_ii <= ai * bi;
    p_ri <= ar * bi;
    p_ir <= ai * br;
    pv   <= en;
    if (clr) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (pv) begin
      acc_re <= acc_re + ACC_W'(p_rr) - ACC_W'(p_ii);
      acc_im <= acc_im + ACC_W'(p_ri) + ACC_W'(p_ir);
    end
  end

  function automatic logic signed [VAL_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] s;
    logic signed [ACC_W-1:0] q;
    s = a + (ACC_W'(1) <<< (FRAC_BITS - 1));
    q = s >>> FRAC_BITS;
    if (q > ACC_W'(32767)) return 16'sh7fff;
    if (q < -ACC_W'(32768)) return 16'sh8000;
    return q[VAL_W-1:0];
  endfunction

  assign res_re = round_sat(acc_re);
  assign res_im = round_sat(acc_im);
endmodule
